>>> sv/dqpc_pkg.sv
// ----------------------------------------------------------------------------
// dqpc_pkg: shared types and constants
// Widths, register map and the X4 quadrature step table for the dual
// quadrature position counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dqpc_pkg;

    localparam int LIMIT_W = 10;
    localparam int POS_W   = 11;
    localparam int SUM_W   = POS_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    // Register index of the position limit (byte address 0).
    localparam logic REG_LIMIT = 1'b0;

    typedef logic [1:0]              phase_t;
    typedef logic signed [1:0]       step_t;
    typedef logic [LIMIT_W-1:0]      limit_t;
    typedef logic signed [POS_W-1:0] pos_t;

    // Index is {previous A, previous B, current A, current B}.
    localparam step_t STEP_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

>>> sv/dqpc_axis.sv
// ----------------------------------------------------------------------------
// dqpc_axis: one quadrature axis
// Holds the last phase, step accumulator and position count of one axis and
// computes the saturated position after each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpc_axis (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    advance,
    input  wire dqpc_pkg::phase_t  phase,
    input  wire dqpc_pkg::limit_t  limit,
    output dqpc_pkg::pos_t         count_next
);

    dqpc_pkg::phase_t       last_phase_reg;
    logic signed [1:0]      half_reg;
    logic signed [1:0]      half_next;
    dqpc_pkg::pos_t         count_reg;

    dqpc_pkg::step_t                    step;
    logic signed [2:0]                  acc;
    logic signed [dqpc_pkg::SUM_W-1:0]  sum;
    logic signed [dqpc_pkg::SUM_W-1:0]  lim_pos;
    logic signed [dqpc_pkg::SUM_W-1:0]  lim_neg;
    logic signed [dqpc_pkg::SUM_W-1:0]  clamped;

    always_comb
    begin
        step    = dqpc_pkg::STEP_TABLE[{last_phase_reg, phase}];
        acc     = 3'(half_reg) + 3'(step);
        sum     = dqpc_pkg::SUM_W'(count_reg);
        lim_pos = $signed({2'b00, limit});
        lim_neg = -lim_pos;
        // Two quadrature steps make one count; drop the accumulator back.
        if (acc >= 3'sd2)
        begin
            sum       = sum + 12'sd1;
            half_next = 2'(acc - 3'sd2);
        end
        else if (acc <= -3'sd2)
        begin
            sum       = sum - 12'sd1;
            half_next = 2'(acc + 3'sd2);
        end
        else
        begin
            half_next = 2'(acc);
        end
        if (sum > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (sum < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = sum;
        end
        count_next = dqpc_pkg::POS_W'(clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= '0;
            half_reg       <= '0;
            count_reg      <= '0;
        end
        else if (advance)
        begin
            last_phase_reg <= phase;
            half_reg       <= half_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/dual_quadrature_position_counter.sv
// ----------------------------------------------------------------------------
// dual_quadrature_position_counter: X/Y quadrature position counter
// Decodes two quadrature encoders (X4 table, two steps per count) into two
// saturated signed position counts, one result transaction per sample.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/tready   phase sample, one per transaction
// m_*       out        m_tvalid/tready   X and Y positions after each sample
// APB       in         psel/penable      position_limit at byte address 0
//
// Timing: each accepted sample's result is registered; one transaction per
// cycle is sustained while m_tready is high, set by the single result register.
// Reset: rst_n clears phases, accumulators, counts and the result valid, and
// loads position_limit with 100.
// Stalls: while m_tready is low a held result blocks s_tready; accept a new
// sample in the same cycle in which the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_quadrature_position_counter (
    input  wire         clk,
    input  wire         rst_n,
    // s_tdata: [0] x_phase_a, [1] x_phase_b, [2] y_phase_a, [3] y_phase_b,
    //          [7:4] zero
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,
    // m_tdata: [10:0] x_position, [21:11] y_position, [23:22] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire         paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dqpc_pkg::limit_t limit_reg;
    logic             m_tvalid_reg;
    dqpc_pkg::pos_t   x_pos_reg;
    dqpc_pkg::pos_t   y_pos_reg;

    dqpc_pkg::pos_t   x_next;
    dqpc_pkg::pos_t   y_next;
    logic             advance;

    // Configuration: a single register, always ready.
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr == dqpc_pkg::REG_LIMIT)
        begin
            prdata = 32'(limit_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= dqpc_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == dqpc_pkg::REG_LIMIT)
        begin
            limit_reg <= pwdata[dqpc_pkg::LIMIT_W-1:0];
        end
    end

    // Take a sample whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign advance  = s_tvalid && s_tready;

    dqpc_axis u_axis_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .phase      ({s_tdata[0], s_tdata[1]}),
        .limit      (limit_reg),
        .count_next (x_next)
    );

    dqpc_axis u_axis_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .phase      ({s_tdata[2], s_tdata[3]}),
        .limit      (limit_reg),
        .count_next (y_next)
    );

    // Result valid: set on a new sample, clear once taken with nothing new.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload: hold while stalled, no reset needed.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_pos_reg <= x_next;
            y_pos_reg <= y_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, y_pos_reg, x_pos_reg};

    a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted sample produced no result");

    a_x_within_limit : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=>
            ($signed(12'(x_pos_reg)) <= $signed({2'b00, $past(limit_reg)}) &&
             $signed(12'(x_pos_reg)) >= -$signed({2'b00, $past(limit_reg)})))
        else $error("X position outside the limit");

    a_y_within_limit : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=>
            ($signed(12'(y_pos_reg)) <= $signed({2'b00, $past(limit_reg)}) &&
             $signed(12'(y_pos_reg)) >= -$signed({2'b00, $past(limit_reg)})))
        else $error("Y position outside the limit");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("sample accepted over a stalled result");

endmodule

`default_nettype wire
